>>> hdl/kar_pkg.sv
// shared widths and register codes for the key auto-repeat tracker
// no dependencies; imported by kar_div and key_auto_repeat_tracker
`timescale 1ns / 1ps
`default_nettype none

package kar_pkg;

    localparam int unsigned IDX_W   = 5;
    localparam int unsigned TICK_W  = 16;
    localparam int unsigned CAP_W   = 8;
    localparam int unsigned ACC_W   = 32;
    localparam int unsigned CFG_W   = 16;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_INITIAL_DELAY   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_INTERVAL = 2'd1;

    localparam logic [CFG_W-1:0] DELAY_RESET    = 16'd500;
    localparam logic [CFG_W-1:0] INTERVAL_RESET = 16'd100;

    typedef struct packed {
        logic                done;
        logic [ACC_W-1:0]    quotient;
        logic [TICK_W-1:0]   remainder;
    } div_result_t;

endpackage

`default_nettype wire

>>> hdl/kar_div.sv
// bit-serial restoring divider: 32-bit accumulator by 16-bit interval
// one quotient bit per cycle; depends on kar_pkg
`timescale 1ns / 1ps
`default_nettype none

module kar_div (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic [kar_pkg::ACC_W-1:0]  dividend,
    input  wire logic [kar_pkg::TICK_W-1:0] divisor,
    output kar_pkg::div_result_t            result
);
    import kar_pkg::*;

    localparam int unsigned CntW = $clog2(ACC_W + 1);

    logic [ACC_W-1:0]  dvd_reg;
    logic [ACC_W-1:0]  quo_reg;
    logic [TICK_W-1:0] rem_reg;
    logic [TICK_W-1:0] dsr_reg;
    logic [CntW-1:0]   cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [TICK_W:0]   trial;
    logic              fits;

    // shift the next dividend bit into the partial remainder
    assign trial = {rem_reg, dvd_reg[ACC_W-1]};
    assign fits  = trial >= {1'b0, dsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CntW'(ACC_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CntW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            quo_reg <= '0;
            rem_reg <= '0;
            // zero interval behaves as one
            dsr_reg <= (divisor == '0) ? TICK_W'(1) : divisor;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[ACC_W-2:0], 1'b0};
            quo_reg <= {quo_reg[ACC_W-2:0], fits};
            rem_reg <= fits ? TICK_W'(trial - {1'b0, dsr_reg}) : trial[TICK_W-1:0];
        end
    end

    assign result.done      = done_reg;
    assign result.quotient  = quo_reg;
    assign result.remainder = rem_reg;

endmodule

`default_nettype wire

>>> hdl/key_auto_repeat_tracker.sv
// key auto-repeat tracker: from accept to result valid, rejects and releases pass S_ADD
// then S_DONE; items that stop at the press or the initial delay also pass S_DELAY; when the
// repeat interval is divided into the accumulator S_DSTART and S_DWAIT follow, and S_MSUB
// when the cap cuts the quotient short; the bit-serial divider (one quotient bit per cycle) sets the wait.
// one request in flight; the next is taken the cycle after the result is parked.
// reset (async, active low): registers 500/100, nothing tracked, accumulator 0.
`timescale 1ns / 1ps
`default_nettype none

module key_auto_repeat_tracker #(
    parameter int unsigned BUTTON_COUNT = 16
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    // configuration write port
    input  wire logic                         cfg_write,
    input  wire logic [kar_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [kar_pkg::CFG_W-1:0]     cfg_data,
    // request channel
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic [kar_pkg::IDX_W-1:0]     button_index,
    input  wire logic                         current_down,
    input  wire logic                         previous_down,
    input  wire logic [kar_pkg::TICK_W-1:0]    elapsed_ticks,
    input  wire logic [kar_pkg::CAP_W-1:0]     catch_up_cap,
    // result channel
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic                              accepted,
    output logic [kar_pkg::CAP_W-1:0]          trigger_count,
    output logic [kar_pkg::TICK_W-1:0]         ticks_to_next
);
    import kar_pkg::*;

    // tracked_button value that means no button is held
    localparam logic [IDX_W-1:0] NoneTracked = IDX_W'(BUTTON_COUNT);
    localparam int unsigned      ProdW       = CAP_W + TICK_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD,     // validate request, add elapsed ticks
        S_DELAY,   // initial delay step
        S_DSTART,  // launch the serial divide
        S_DWAIT,   // wait for quotient, apply catch-up cap
        S_MSUB,    // cap hit: take remaining cap * interval off the accumulator
        S_DONE     // park the result in the output register
    } state_t;

    state_t            state_reg;

    // configuration and tracking state
    logic [CFG_W-1:0]  cfg_delay_reg;
    logic [CFG_W-1:0]  cfg_interval_reg;
    logic [CFG_W-1:0]  active_delay_reg;
    logic [CFG_W-1:0]  active_interval_reg;
    logic [ACC_W-1:0]  accum_reg;
    logic [IDX_W-1:0]  tracked_reg;
    logic              repeating_reg;

    // per-request working values
    logic              res_acc_reg;
    logic [CAP_W-1:0]  tc_reg;
    logic              out_valid_reg;

    // request latch (payload, no reset)
    logic [IDX_W-1:0]  idx_reg;
    logic              cur_reg;
    logic              prev_reg;
    logic [TICK_W-1:0] elapsed_reg;
    logic [CAP_W-1:0]  cap_reg;
    logic [ProdW-1:0]  prod_reg;

    logic [0:0]        acc_out_reg;
    logic [CAP_W-1:0]  tc_out_reg;
    logic [TICK_W-1:0] ttn_out_reg;

    // serial divider
    logic              div_start;
    div_result_t       div_res;

    // combinational helpers
    logic              tracking;
    logic              bad_req;
    logic              starts;
    logic [ACC_W:0]    sum_w;
    logic [CAP_W:0]    tc_inc;
    logic [CAP_W-1:0]  remaining;
    logic              q_ge;
    logic              out_free;
    logic              in_take;
    logic [CFG_W-1:0]  dur;
    logic [TICK_W-1:0] ttn;

    assign in_take  = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);
    assign out_free = !out_valid_reg || !out_stall;

    assign tracking = (tracked_reg != NoneTracked);
    // out-of-range button, zero cap, or a second button while one is held
    assign bad_req  = (idx_reg >= NoneTracked) || (cap_reg == '0)
                      || (tracking && (idx_reg != tracked_reg));
    // fresh press also when the edge was missed while nothing was tracked
    assign starts   = !prev_reg || !tracking;
    assign sum_w    = {1'b0, (starts ? '0 : accum_reg)} + (ACC_W + 1)'(elapsed_reg);

    assign tc_inc    = {1'b0, tc_reg} + 1'b1;
    assign remaining = cap_reg - tc_reg;
    // quotient at or above what the cap still allows
    assign q_ge      = (|div_res.quotient[ACC_W-1:CAP_W])
                       || (div_res.quotient[CAP_W-1:0] >= remaining);

    assign div_start = (state_reg == S_DSTART);

    // ticks until next trigger, from the state after the request
    assign dur = repeating_reg ? active_interval_reg : active_delay_reg;
    always_comb
    begin
        if (tracking && ((ACC_W)'(dur) > accum_reg))
        begin
            ttn = TICK_W'(dur - accum_reg[TICK_W-1:0]);
        end
        else
        begin
            ttn = '0;
        end
    end

    kar_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (accum_reg),
        .divisor  (active_interval_reg),
        .result   (div_res)
    );

    // sequencer, tracking state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= S_IDLE;
            cfg_delay_reg       <= DELAY_RESET;
            cfg_interval_reg    <= INTERVAL_RESET;
            active_delay_reg    <= DELAY_RESET;
            active_interval_reg <= INTERVAL_RESET;
            accum_reg           <= '0;
            tracked_reg         <= NoneTracked;
            repeating_reg       <= 1'b0;
            res_acc_reg         <= 1'b0;
            tc_reg              <= '0;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            // zero writes are dropped; while nothing is tracked the active copy follows
            if (cfg_write && (cfg_data != '0))
            begin
                if (cfg_index == REG_INITIAL_DELAY)
                begin
                    cfg_delay_reg <= cfg_data;
                    if (!tracking)
                    begin
                        active_delay_reg <= cfg_data;
                    end
                end
                else if (cfg_index == REG_REPEAT_INTERVAL)
                begin
                    cfg_interval_reg <= cfg_data;
                    if (!tracking)
                    begin
                        active_interval_reg <= cfg_data;
                    end
                end
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_take)
                    begin
                        state_reg <= S_ADD;
                    end
                end

                S_ADD:
                begin
                    priority if (bad_req)
                    begin
                        res_acc_reg <= 1'b0;
                        tc_reg      <= '0;
                        state_reg   <= S_DONE;
                    end
                    else if (!cur_reg)
                    begin
                        // release drops tracking and re-latches the registers
                        active_delay_reg    <= cfg_delay_reg;
                        active_interval_reg <= cfg_interval_reg;
                        accum_reg           <= '0;
                        tracked_reg         <= NoneTracked;
                        repeating_reg       <= 1'b0;
                        res_acc_reg         <= 1'b1;
                        tc_reg              <= '0;
                        state_reg           <= S_DONE;
                    end
                    else if (sum_w[ACC_W])
                    begin
                        // accumulator overflow rejects, state untouched
                        res_acc_reg <= 1'b0;
                        tc_reg      <= '0;
                        state_reg   <= S_DONE;
                    end
                    else
                    begin
                        if (starts)
                        begin
                            active_delay_reg    <= cfg_delay_reg;
                            active_interval_reg <= cfg_interval_reg;
                            tracked_reg         <= idx_reg;
                            repeating_reg       <= 1'b0;
                        end
                        accum_reg   <= sum_w[ACC_W-1:0];
                        res_acc_reg <= 1'b1;
                        tc_reg      <= CAP_W'(starts);
                        state_reg   <= S_DELAY;
                    end
                end

                S_DELAY:
                begin
                    priority if (tc_reg >= cap_reg)
                    begin
                        state_reg <= S_DONE;
                    end
                    else if (repeating_reg)
                    begin
                        state_reg <= S_DSTART;
                    end
                    else if (accum_reg < ACC_W'(active_delay_reg))
                    begin
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        // initial delay elapsed: first repeat trigger
                        accum_reg     <= accum_reg - ACC_W'(active_delay_reg);
                        repeating_reg <= 1'b1;
                        tc_reg        <= tc_inc[CAP_W-1:0];
                        state_reg     <= (tc_inc >= {1'b0, cap_reg}) ? S_DONE : S_DSTART;
                    end
                end

                S_DSTART:
                begin
                    state_reg <= S_DWAIT;
                end

                S_DWAIT:
                begin
                    if (div_res.done)
                    begin
                        if (q_ge)
                        begin
                            // cap reached, surplus intervals stay banked
                            tc_reg    <= cap_reg;
                            state_reg <= S_MSUB;
                        end
                        else
                        begin
                            accum_reg <= ACC_W'(div_res.remainder);
                            tc_reg    <= tc_reg + div_res.quotient[CAP_W-1:0];
                            state_reg <= S_DONE;
                        end
                    end
                end

                S_MSUB:
                begin
                    accum_reg <= accum_reg - ACC_W'(prod_reg);
                    state_reg <= S_DONE;
                end

                S_DONE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // request latch
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            idx_reg     <= button_index;
            cur_reg     <= current_down;
            prev_reg    <= previous_down;
            elapsed_reg <= elapsed_ticks;
            cap_reg     <= catch_up_cap;
        end
    end

    // remaining cap * interval, registered ahead of the subtract
    always_ff @(posedge clk)
    begin
        if ((state_reg == S_DWAIT) && div_res.done && q_ge)
        begin
            prod_reg <= ProdW'(remaining) * ProdW'(active_interval_reg);
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if ((state_reg == S_DONE) && out_free)
        begin
            acc_out_reg <= res_acc_reg;
            tc_out_reg  <= tc_reg;
            ttn_out_reg <= ttn;
        end
    end

    assign out_valid     = out_valid_reg;
    assign accepted      = acc_out_reg[0];
    assign trigger_count = tc_out_reg;
    assign ticks_to_next = ttn_out_reg;

    // nothing tracked means a cleared accumulator and no repeat phase
    a_idle_clear : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) && !tracking |-> (accum_reg == '0) && !repeating_reg)
        else $error("idle tracker holds stale timing state");

    // divider only reports while the sequencer waits for it
    a_div_done : assert property (@(posedge clk) disable iff (!rst_n)
        div_res.done |-> (state_reg == S_DWAIT))
        else $error("divider finished outside wait state");

    // triggers never exceed the cap of the request
    a_cap : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE) |-> (tc_reg <= cap_reg) || !res_acc_reg)
        else $error("trigger count above catch-up cap");

    // a rejected request carries no triggers
    a_reject : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE) && !res_acc_reg |-> (tc_reg == '0))
        else $error("rejected request reports triggers");

    // a new request only enters after the previous result is parked
    a_one_inflight : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE) && out_free |=> (state_reg == S_IDLE) && out_valid_reg)
        else $error("result hand-off lost");

endmodule

`default_nettype wire
